// ----- design/hsd_pkg.sv -----
// Shared types, constants and the quarter-round word map for the HSalsa20 subkey pipeline.
`default_nettype none
package hsd_pkg;

  typedef struct packed {
    logic [63:0] nonce_high;
    logic [63:0] nonce_low;
  } request_t;

  typedef struct packed {
    logic [63:0] subkey_part3;
    logic [63:0] subkey_part2;
    logic [63:0] subkey_part1;
    logic [63:0] subkey_part0;
  } result_t;

  typedef logic [15:0][31:0] state_t;

  typedef enum logic [1:0] {
    KEY_PART0 = 2'd0,
    KEY_PART1 = 2'd1,
    KEY_PART2 = 2'd2,
    KEY_PART3 = 2'd3
  } cfg_index_t;

  localparam logic [31:0] SIGMA0 = 32'h6170_7865;
  localparam logic [31:0] SIGMA1 = 32'h3320_646e;
  localparam logic [31:0] SIGMA2 = 32'h7962_2d32;
  localparam logic [31:0] SIGMA3 = 32'h6b20_6574;

  localparam int STEPS_PER_DOUBLE_ROUND = 8;

  // rotate amount of each add-rotate-xor step of a quarter round
  localparam int ROT_AMT [0:3] = '{7, 9, 13, 18};

  // word positions a, b, c, d of each quarter round, column round then row round
  localparam logic [3:0] QR_MAP [0:1][0:3][0:3] = '{
    '{'{4'd0,  4'd4,  4'd8,  4'd12},
      '{4'd5,  4'd9,  4'd13, 4'd1 },
      '{4'd10, 4'd14, 4'd2,  4'd6 },
      '{4'd15, 4'd3,  4'd7,  4'd11}},
    '{'{4'd0,  4'd1,  4'd2,  4'd3 },
      '{4'd5,  4'd6,  4'd7,  4'd4 },
      '{4'd10, 4'd11, 4'd8,  4'd9 },
      '{4'd15, 4'd12, 4'd13, 4'd14}}
  };

  function automatic logic [3:0] qr_word(input logic row, input logic [1:0] quarter,
                                         input logic [1:0] pos);
    return QR_MAP[row][quarter][pos];
  endfunction

endpackage
`default_nettype wire

// ----- design/hsd_step.sv -----
// One add-rotate-xor step of all four quarter rounds of a column or row round, registered.
`default_nettype none
module hsd_step #(
  parameter bit ROW  = 1'b0,
  parameter int STEP = 0
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            valid_in,
  input  wire hsd_pkg::state_t state_in,
  output logic                 valid,
  output hsd_pkg::state_t      state
);
  import hsd_pkg::*;

  localparam logic [1:0] SRC_A = 2'(STEP);
  localparam logic [1:0] SRC_B = 2'((STEP + 3) % 4);
  localparam logic [1:0] DST   = 2'((STEP + 1) % 4);
  localparam int         ROT   = ROT_AMT[STEP];

  state_t      state_next;
  logic [31:0] sum;

  always_comb begin
    state_next = state_in;
    sum        = '0;
    for (int q = 0; q < 4; q++) begin
      sum = state_in[qr_word(ROW, 2'(q), SRC_A)] + state_in[qr_word(ROW, 2'(q), SRC_B)];
      state_next[qr_word(ROW, 2'(q), DST)] =
        state_in[qr_word(ROW, 2'(q), DST)] ^ ((sum << ROT) | (sum >> (32 - ROT)));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    state <= state_next;
  end

endmodule
`default_nettype wire

// ----- design/hsalsa20_subkey_derive_top.sv -----
// Top level of the HSalsa20 subkey pipeline: key registers, state load and round stages.
// A request is registered in the state load stage, then runs through every round stage to done.
// Throughput: one request per cycle; every add-rotate-xor step of the rounds is its own stage.
// The receiver cannot stall; done is a one-cycle strobe and the pipeline never holds.
// Reset clears the key registers and every stage valid bit; busy is high only during reset.
`default_nettype none
module hsalsa20_subkey_derive_top #(
  parameter int DOUBLE_ROUNDS = 10
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire hsd_pkg::request_t request,
  output logic                   done,
  output hsd_pkg::result_t       result,
  input  wire logic              cfg_write,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [63:0]       cfg_data
);
  import hsd_pkg::*;

  localparam int NSTAGE = STEPS_PER_DOUBLE_ROUND * DOUBLE_ROUNDS;

  logic [3:0][63:0] key;
  logic             stage_valid [0:NSTAGE];
  state_t           stage_state [0:NSTAGE];
  state_t           init_state;

  assign busy = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (cfg_write) begin
      case (cfg_index_t'(cfg_index))
        KEY_PART0: key[0] <= cfg_data;
        KEY_PART1: key[1] <= cfg_data;
        KEY_PART2: key[2] <= cfg_data;
        KEY_PART3: key[3] <= cfg_data;
        default: key <= key;
      endcase
    end
  end

  always_comb begin
    init_state[0]  = SIGMA0;
    init_state[1]  = key[0][31:0];
    init_state[2]  = key[0][63:32];
    init_state[3]  = key[1][31:0];
    init_state[4]  = key[1][63:32];
    init_state[5]  = SIGMA1;
    init_state[6]  = request.nonce_low[31:0];
    init_state[7]  = request.nonce_low[63:32];
    init_state[8]  = request.nonce_high[31:0];
    init_state[9]  = request.nonce_high[63:32];
    init_state[10] = SIGMA2;
    init_state[11] = key[2][31:0];
    init_state[12] = key[2][63:32];
    init_state[13] = key[3][31:0];
    init_state[14] = key[3][63:32];
    init_state[15] = SIGMA3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid[0] <= 1'b0;
    end else begin
      stage_valid[0] <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    stage_state[0] <= init_state;
  end

  for (genvar g = 0; g < NSTAGE; g++) begin : g_step
    hsd_step #(
      .ROW  (((g / 4) % 2) == 1),
      .STEP (g % 4)
    ) u_step (
      .clk      (clk),
      .rst      (rst),
      .valid_in (stage_valid[g]),
      .state_in (stage_state[g]),
      .valid    (stage_valid[g+1]),
      .state    (stage_state[g+1])
    );
  end

  assign done                = stage_valid[NSTAGE];
  assign result.subkey_part0 = {stage_state[NSTAGE][5],  stage_state[NSTAGE][0]};
  assign result.subkey_part1 = {stage_state[NSTAGE][15], stage_state[NSTAGE][10]};
  assign result.subkey_part2 = {stage_state[NSTAGE][7],  stage_state[NSTAGE][6]};
  assign result.subkey_part3 = {stage_state[NSTAGE][9],  stage_state[NSTAGE][8]};

endmodule
`default_nettype wire

// ----- design/hsd_checker.sv -----
// Port-level checks of request-to-done timing for the HSalsa20 subkey pipeline, with its bind.
`default_nettype none
module hsd_checker #(
  parameter int DOUBLE_ROUNDS = 10
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic done
);
  localparam int LAT = 8 * DOUBLE_ROUNDS + 1;
  localparam int CW  = $clog2(LAT + 2);

  logic [CW-1:0] since_rst;
  logic          accept;

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      since_rst <= '0;
    end else if (since_rst <= CW'(LAT)) begin
      since_rst <= since_rst + 1'b1;
    end
  end

  a_quiet_after_reset: assert property (@(posedge clk) rst |=> !done)
    else $error("done raised in the cycle after reset");

  a_done_has_request: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LAT))
    else $error("done without a request accepted at the pipeline latency");

  a_request_gives_done: assert property (@(posedge clk) disable iff (rst)
    (since_rst > CW'(LAT)) && $past(accept, LAT) |-> done)
    else $error("accepted request produced no done");

  a_busy_only_in_reset: assert property (@(posedge clk) disable iff (rst)
    $fell(rst) |-> !busy)
    else $error("busy held after reset release");

endmodule

bind hsalsa20_subkey_derive_top hsd_checker #(
  .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
) u_hsd_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);
`default_nettype wire
